FILE: rtl/frg_pkg.sv
// ----------------------------------------------------------------------------
// frg_pkg
// Shared types and constants for the fraction reduction unit.
// ----------------------------------------------------------------------------
package frg_pkg;

	// width of the numerator, denominator and common factor ports
	localparam int DATA_WIDTH = 64;

	// default working width of the arithmetic
	localparam int DEF_VALUE_WIDTH = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUCLID,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_FINISH
	} frg_state_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} frg_div_req_t;

	typedef struct packed {
		logic done;
	} frg_div_stat_t;

endpackage

FILE: rtl/frg_divider.sv
// ----------------------------------------------------------------------------
// frg_divider
// Restoring radix-2 divider, one quotient bit per cycle. Gives quotient and
// remainder; the results hold until the next start.
// ----------------------------------------------------------------------------
module frg_divider #(
	parameter int VALUE_WIDTH = frg_pkg::DEF_VALUE_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frg_pkg::frg_div_req_t      req,
	input  logic [VALUE_WIDTH-1:0]     dividend,
	input  logic [VALUE_WIDTH-1:0]     divisor,
	output frg_pkg::frg_div_stat_t     stat,
	output logic [VALUE_WIDTH-1:0]     quotient,
	output logic [VALUE_WIDTH-1:0]     remainder
);
	import frg_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = ~diff[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(VALUE_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so its low bits are enough
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/fraction_reduce_gcd_unit.sv
// ----------------------------------------------------------------------------
// fraction_reduce_gcd_unit
// Reduces an unsigned fraction to lowest terms with Euclid's algorithm.
// ----------------------------------------------------------------------------
// One item at a time. Every division goes through a single shared restoring
// divider that gives one quotient bit a cycle once loaded. An item with k
// remainder steps needs k + 2 divisions: the k Euclid steps, then the
// numerator and the denominator by the common factor. k is at most about 93
// at 64 bits. A zero denominator goes from ST_IDLE straight to ST_FINISH
// with zero_denominator set, the numerator passed through, and zero
// denominator and common factor. Operand bits above VALUE_WIDTH are ignored.
// The input is ready only while no item is in work; a finished result waits
// in the output register while the next item is taken.
module fraction_reduce_gcd_unit #(
	parameter int VALUE_WIDTH = frg_pkg::DEF_VALUE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [frg_pkg::DATA_WIDTH-1:0]   numerator_in,
	input  logic [frg_pkg::DATA_WIDTH-1:0]   denominator_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [frg_pkg::DATA_WIDTH-1:0]   numerator_out,
	output logic [frg_pkg::DATA_WIDTH-1:0]   denominator_out,
	output logic [frg_pkg::DATA_WIDTH-1:0]   common_factor,
	output logic                             zero_denominator
);
	import frg_pkg::*;

	localparam int W = VALUE_WIDTH;

	frg_state_t     state_q, state_d;
	frg_div_req_t   div_req;
	frg_div_stat_t  div_stat;
	logic [W-1:0]   div_a, div_b;
	logic [W-1:0]   div_quo, div_rem;

	logic [W-1:0]   n_in_m, d_in_m;
	logic [W-1:0]   n_q, d_q, y_q;
	logic [W-1:0]   nres_q, dres_q;
	logic           zd_q;
	logic           accept;
	logic           out_free;
	logic           out_load;

	logic [DATA_WIDTH-1:0] num_out_q, den_out_q, gcd_out_q;
	logic                  zd_out_q;
	logic                  out_valid_q;

	assign n_in_m   = numerator_in[W-1:0];
	assign d_in_m   = denominator_in[W-1:0];
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (d_in_m == '0) ? ST_FINISH : ST_EUCLID;
				end
			end
			ST_EUCLID: begin
				if (div_stat.done && div_rem == '0) begin
					state_d = ST_DIV_NUM;
				end
			end
			ST_DIV_NUM: begin
				if (div_stat.done) begin
					state_d = ST_DIV_DEN;
				end
			end
			ST_DIV_DEN: begin
				if (div_stat.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready      = 1'b0;
		div_req.start = 1'b0;
		div_a         = y_q;
		div_b         = div_rem;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				div_a    = n_in_m;
				div_b    = d_in_m;
				if (in_valid && d_in_m != '0) begin
					div_req.start = 1'b1;
				end
			end
			ST_EUCLID: begin
				if (div_stat.done) begin
					div_req.start = 1'b1;
					if (div_rem == '0) begin
						// divisor found, now n / gcd
						div_a = n_q;
						div_b = y_q;
					end else begin
						div_a = y_q;
						div_b = div_rem;
					end
				end
			end
			ST_DIV_NUM: begin
				div_a = d_q;
				div_b = y_q;
				if (div_stat.done) begin
					div_req.start = 1'b1;
				end
			end
			ST_DIV_DEN: begin
				div_a = d_q;
				div_b = y_q;
			end
			ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= n_in_m;
			d_q    <= d_in_m;
			y_q    <= d_in_m;
			zd_q   <= (d_in_m == '0);
			// zero denominator passes the operands through
			nres_q <= n_in_m;
			dres_q <= '0;
		end else begin
			if (state_q == ST_EUCLID && div_stat.done && div_rem != '0) begin
				y_q <= div_rem;
			end
			if (state_q == ST_DIV_NUM && div_stat.done) begin
				nres_q <= div_quo;
			end
			if (state_q == ST_DIV_DEN && div_stat.done) begin
				dres_q <= div_quo;
			end
		end
	end

	frg_divider #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_a),
		.divisor   (div_b),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			num_out_q <= DATA_WIDTH'(nres_q);
			den_out_q <= DATA_WIDTH'(dres_q);
			gcd_out_q <= DATA_WIDTH'(y_q);
			zd_out_q  <= zd_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign numerator_out    = num_out_q;
	assign denominator_out  = den_out_q;
	assign common_factor    = gcd_out_q;
	assign zero_denominator = zd_out_q;

endmodule
